[rtl/zac_pkg.sv]
`default_nettype none
package zac_pkg;
    localparam int COLUMNS     = 256;
    localparam int ROWS        = 128;
    localparam int SAMPLE_BITS = 16;

    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CELL_W = COL_W + ROW_W;
    localparam int CELLS  = COLUMNS * ROWS;

    localparam int SUM_W  = 25;
    localparam int CNT_W  = 9;
    localparam int ANOM_W = 18;
    localparam int OUT_AW = 17;
    localparam int T_W    = 16;

    localparam int DIV_QW = SUM_W;
    localparam int DIV_RW = ANOM_W;
    localparam int DIV_CW = $clog2(DIV_QW + 1);

    localparam int SMAX = (2 ** (SAMPLE_BITS - 1)) - 1;

    typedef struct packed {
        logic cap;
        logic fr_wr;
        logic fr_rd;
        logic sc_rd;
        logic sc_wr;
        logic mean_rd;
        logic mean_wr;
        logic scan;
        logic cnt_clr;
        logic col_inc;
        logic row_inc;
        logic stat_clr;
        logic div_mean;
        logic div_pix;
        logic out_sum;
        logic out_pix;
    } t_cmd;

    typedef struct packed {
        logic col_last;
        logic row_last;
        logic div_busy;
        logic out_free;
    } t_sts;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_PIXEL  = 2'd2;

    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = CELL_W'(r) * CELL_W'(COLUMNS) + CELL_W'(c);
    endfunction
endpackage
`default_nettype wire

[rtl/zac_div.sv]
`default_nettype none
module zac_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire                              i_feed_q,
    input  wire [zac_pkg::DIV_RW-1:0]        i_rem0,
    input  wire [zac_pkg::DIV_QW-1:0]        i_q0,
    input  wire [zac_pkg::DIV_RW-1:0]        i_den,
    input  wire [zac_pkg::DIV_CW-1:0]        i_iters,
    output logic                             o_busy,
    output logic [zac_pkg::DIV_QW-1:0]       o_q
);
    logic [zac_pkg::DIV_RW-1:0] r_rem, n_rem, r_den;
    logic [zac_pkg::DIV_QW-1:0] r_q, n_q;
    logic [zac_pkg::DIV_CW-1:0] r_cnt;
    logic                       r_busy, r_feed;
    logic [zac_pkg::DIV_RW:0]   sh;
    logic                       qb;

    always_comb begin
        sh = {r_rem, r_feed & r_q[zac_pkg::DIV_QW-1]};
        qb = (sh >= {1'b0, r_den});
        n_rem = qb ? zac_pkg::DIV_RW'(sh - {1'b0, r_den}) : sh[zac_pkg::DIV_RW-1:0];
        n_q = {r_q[zac_pkg::DIV_QW-2:0], qb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == zac_pkg::DIV_CW'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem0;
            r_q    <= i_q0;
            r_den  <= i_den;
            r_feed <= i_feed_q;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_q;
endmodule
`default_nettype wire

[rtl/zac_ctrl.sv]
`default_nettype none
module zac_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire [1:0]           i_mode,
    output logic                o_ready,
    input  wire zac_pkg::t_sts  i_sts,
    output zac_pkg::t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LD_RD   = 4'd1;
    localparam logic [3:0] S_LD_WR   = 4'd2;
    localparam logic [3:0] S_F_INIT  = 4'd3;
    localparam logic [3:0] S_F_ROW   = 4'd4;
    localparam logic [3:0] S_F_DIVS  = 4'd5;
    localparam logic [3:0] S_F_DIV   = 4'd6;
    localparam logic [3:0] S_F_MEAN  = 4'd7;
    localparam logic [3:0] S_F_SCAN  = 4'd8;
    localparam logic [3:0] S_F_DRAIN = 4'd9;
    localparam logic [3:0] S_F_OUT   = 4'd10;
    localparam logic [3:0] S_P_RD    = 4'd11;
    localparam logic [3:0] S_P_CHK   = 4'd12;
    localparam logic [3:0] S_P_DIV   = 4'd13;
    localparam logic [3:0] S_P_OUT   = 4'd14;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    case (i_mode)
                        zac_pkg::MODE_LOAD:   n_state = S_LD_RD;
                        zac_pkg::MODE_FINISH: n_state = S_F_INIT;
                        zac_pkg::MODE_PIXEL:  n_state = S_P_RD;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_RD: begin
                o_cmd.fr_wr = 1'b1;
                o_cmd.sc_rd = 1'b1;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.sc_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_F_INIT: begin
                o_cmd.cnt_clr  = 1'b1;
                o_cmd.stat_clr = 1'b1;
                n_state = S_F_ROW;
            end
            S_F_ROW: begin
                o_cmd.sc_rd = 1'b1;
                o_cmd.scan  = 1'b1;
                n_state = S_F_DIVS;
            end
            S_F_DIVS: begin
                o_cmd.div_mean = 1'b1;
                n_state = S_F_DIV;
            end
            S_F_DIV: begin
                if (!i_sts.div_busy) n_state = S_F_MEAN;
            end
            S_F_MEAN: begin
                o_cmd.mean_wr = 1'b1;
                n_state = S_F_SCAN;
            end
            S_F_SCAN: begin
                o_cmd.fr_rd   = 1'b1;
                o_cmd.scan    = 1'b1;
                o_cmd.col_inc = 1'b1;
                if (i_sts.col_last) n_state = S_F_DRAIN;
            end
            S_F_DRAIN: begin
                if (i_sts.row_last) begin
                    n_state = S_F_OUT;
                end else begin
                    o_cmd.row_inc = 1'b1;
                    n_state = S_F_ROW;
                end
            end
            S_F_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sum = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_P_RD: begin
                o_cmd.fr_rd   = 1'b1;
                o_cmd.mean_rd = 1'b1;
                n_state = S_P_CHK;
            end
            S_P_CHK: begin
                o_cmd.div_pix = 1'b1;
                n_state = S_P_DIV;
            end
            S_P_DIV: begin
                if (!i_sts.div_busy) n_state = S_P_OUT;
            end
            S_P_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_pix = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

[rtl/zac_dp.sv]
`default_nettype none
module zac_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire zac_pkg::t_cmd  i_cmd,
    output zac_pkg::t_sts       o_sts,
    input  wire [7:0]           i_column,
    input  wire [6:0]           i_row,
    input  wire [15:0]          i_sample,
    input  wire                 i_sample_valid,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output logic                o_kind,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [16:0]         o_anomaly_low,
    output logic [16:0]         o_anomaly_high
);
    localparam int SB = zac_pkg::SAMPLE_BITS;
    localparam int AW = zac_pkg::ANOM_W;
    localparam int QW = zac_pkg::DIV_QW;
    localparam int RW = zac_pkg::DIV_RW;
    localparam int SCW = zac_pkg::SUM_W + zac_pkg::CNT_W;
    localparam int T_WL = zac_pkg::T_W;

    logic [7:0]    r_col;
    logic [6:0]    r_row;
    logic [SB-1:0] r_smp;
    logic          r_sv;

    logic [SB:0]   m_frame [zac_pkg::CELLS];
    logic [SCW-1:0] m_sc   [zac_pkg::ROWS];
    logic [SB-1:0] m_mean  [zac_pkg::ROWS];
    logic [zac_pkg::ROWS-1:0] r_row_vld;

    logic [SB:0]    r_fq;
    logic           r_fscan;
    logic [SCW-1:0] r_scq;
    logic           r_scv;
    logic [SB-1:0]  r_meanq, r_mean_cur;

    logic [zac_pkg::ROW_W-1:0] r_frow;
    logic [zac_pkg::COL_W-1:0] r_fcol;

    logic signed [AW-1:0] r_lo, r_hi;
    logic                 r_any;
    logic                 r_neg, r_czero;
    logic                 r_red, r_tz, r_tf;

    logic                 in_grid;
    logic [zac_pkg::ROW_W-1:0] in_row;
    logic [zac_pkg::CELL_W-1:0] in_addr, scan_addr, fr_addr;
    logic [zac_pkg::ROW_W-1:0] sc_addr;
    logic [zac_pkg::SUM_W-1:0] sum;
    logic [zac_pkg::CNT_W-1:0] cnt;
    logic [QW-1:0]        sum_mag;
    logic [SB-1:0]        mean_val;
    logic signed [AW-1:0] acc_a, pix_a;
    logic signed [AW:0]   diff, range;
    logic                 d_zero, d_full;

    logic                 div_start, div_busy, div_feed;
    logic [RW-1:0]        div_rem0, div_den;
    logic [QW-1:0]        div_q0, div_q;
    logic [zac_pkg::DIV_CW-1:0] div_iters;

    logic [T_WL-1:0]      t;
    logic [T_WL-1:0]      l;
    logic [23:0]          p255, p155;
    logic [24:0]          c255, c155;
    logic [7:0]           pr, pg, pb;
    logic                 r_ov;

    assign in_grid   = (32'(r_col) < zac_pkg::COLUMNS) && (32'(r_row) < zac_pkg::ROWS);
    assign in_row    = zac_pkg::ROW_W'(r_row);
    assign in_addr   = zac_pkg::cell_addr(in_row, zac_pkg::COL_W'(r_col));
    assign scan_addr = zac_pkg::cell_addr(r_frow, r_fcol);
    assign fr_addr   = i_cmd.scan ? scan_addr : in_addr;
    assign sc_addr   = i_cmd.scan ? r_frow : in_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_col <= i_column;
            r_row <= i_row;
            r_smp <= SB'(i_sample);
            r_sv  <= i_sample_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fr_wr && in_grid) m_frame[in_addr] <= {r_sv, r_smp};
        if (i_cmd.fr_rd) r_fq <= m_frame[fr_addr];
    end

    assign sum = r_scv ? r_scq[zac_pkg::SUM_W-1:0] : '0;
    assign cnt = r_scv ? r_scq[SCW-1:zac_pkg::SUM_W] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_rd) r_scq <= m_sc[sc_addr];
        if (i_cmd.sc_wr && in_grid && r_sv)
            m_sc[in_row] <= {cnt + 1'b1,
                             sum + zac_pkg::SUM_W'($signed(r_smp))};
        if (i_cmd.mean_wr) m_mean[r_frow] <= mean_val;
        if (i_cmd.mean_rd) r_meanq <= m_mean[in_row];
        if (i_cmd.mean_wr) r_mean_cur <= mean_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_scv     <= 1'b0;
            r_fscan   <= 1'b0;
        end else begin
            if (i_cmd.sc_rd) r_scv <= r_row_vld[sc_addr];
            if (i_cmd.sc_wr && in_grid && r_sv) r_row_vld[in_row] <= 1'b1;
            r_fscan <= i_cmd.fr_rd && i_cmd.scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frow <= '0;
            r_fcol <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_frow <= '0;
            r_fcol <= '0;
        end else begin
            if (i_cmd.col_inc)
                r_fcol <= o_sts.col_last ? '0 : r_fcol + 1'b1;
            if (i_cmd.row_inc) r_frow <= r_frow + 1'b1;
        end
    end

    assign o_sts.col_last = (32'(r_fcol) == zac_pkg::COLUMNS - 1);
    assign o_sts.row_last = (32'(r_frow) == zac_pkg::ROWS - 1);
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_free = !r_ov || i_out_ready;

    // mean: truncated toward zero, saturated to sample width
    assign sum_mag = sum[zac_pkg::SUM_W-1] ? QW'(-sum) : QW'(sum);
    always_comb begin
        if (r_czero)
            mean_val = '0;
        else if (r_neg)
            mean_val = (div_q > QW'(zac_pkg::SMAX)) ? {1'b1, {(SB-1){1'b0}}}
                                                    : SB'(-div_q[SB-1:0]);
        else
            mean_val = (div_q > QW'(zac_pkg::SMAX)) ? SB'(zac_pkg::SMAX)
                                                    : div_q[SB-1:0];
    end

    assign acc_a = AW'($signed(r_fq[SB-1:0])) - AW'($signed(r_mean_cur));
    assign pix_a = AW'($signed(r_fq[SB-1:0])) - AW'($signed(r_meanq));
    assign diff  = (AW+1)'(pix_a) - (AW+1)'(r_lo);
    assign range = (AW+1)'(r_hi) - (AW+1)'(r_lo);
    assign d_zero = (diff <= 0);
    assign d_full = !d_zero && (diff >= range);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo  <= {1'b0, {(AW-1){1'b1}}};
            r_hi  <= {1'b1, {(AW-1){1'b0}}};
            r_any <= 1'b0;
        end else if (i_cmd.stat_clr) begin
            r_lo  <= {1'b0, {(AW-1){1'b1}}};
            r_hi  <= {1'b1, {(AW-1){1'b0}}};
            r_any <= 1'b0;
        end else if (r_fscan && r_fq[SB]) begin
            if (acc_a < r_lo) r_lo <= acc_a;
            if (acc_a > r_hi) r_hi <= acc_a;
            r_any <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_mean) begin
            r_neg   <= sum[zac_pkg::SUM_W-1];
            r_czero <= (cnt == '0);
        end
        if (i_cmd.div_pix) begin
            r_red <= !in_grid || !r_fq[SB] || !r_any || (range <= 0);
            r_tz  <= d_zero;
            r_tf  <= d_full;
        end
    end

    always_comb begin
        div_start = i_cmd.div_mean || i_cmd.div_pix;
        div_feed  = i_cmd.div_mean;
        if (i_cmd.div_mean) begin
            div_rem0  = '0;
            div_q0    = sum_mag;
            div_den   = RW'(cnt);
            div_iters = zac_pkg::DIV_CW'(QW);
        end else begin
            div_rem0  = (d_zero || d_full) ? '0 : diff[RW-1:0];
            div_q0    = '0;
            div_den   = range[RW-1:0];
            div_iters = zac_pkg::DIV_CW'(T_WL);
        end
    end

    zac_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_feed_q (div_feed),
        .i_rem0   (div_rem0),
        .i_q0     (div_q0),
        .i_den    (div_den),
        .i_iters  (div_iters),
        .o_busy   (div_busy),
        .o_q      (div_q)
    );

    // diverging colormap
    always_comb begin
        t    = r_tz ? '0 : (r_tf ? '1 : div_q[T_WL-1:0]);
        l    = {t[T_WL-2:0], 1'b0};
        p255 = 24'(l) * 24'd255;
        p155 = 24'(l) * 24'd155;
        c255 = 25'(p255) + 25'd65535;
        c155 = 25'(p155) + 25'd65535;
        if (r_red) begin
            pr = 8'd255; pg = 8'd100; pb = 8'd0;
        end else if (!t[T_WL-1]) begin
            pr = p255[23:16];
            pg = 8'd100 + p155[23:16];
            pb = 8'd255;
        end else begin
            pr = 8'd255;
            pg = 8'd255 - c155[23:16];
            pb = 8'd255 - c255[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_sum || i_cmd.out_pix) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_sum) begin
            o_kind         <= 1'b1;
            o_red          <= '0;
            o_green        <= '0;
            o_blue         <= '0;
            o_anomaly_low  <= r_any ? r_lo[zac_pkg::OUT_AW-1:0] : '0;
            o_anomaly_high <= r_any ? r_hi[zac_pkg::OUT_AW-1:0] : '0;
        end else if (i_cmd.out_pix) begin
            o_kind         <= 1'b0;
            o_red          <= pr;
            o_green        <= pg;
            o_blue         <= pb;
            o_anomaly_low  <= '0;
            o_anomaly_high <= '0;
        end
    end

    assign o_out_valid = r_ov;
endmodule
`default_nettype wire

[rtl/zonal_anomaly_colormap.sv]
// Channel  | Dir | Beat fields
// s_axis   | in  | tuser: mode; tdata: column, row, sample, sample_valid
// m_axis   | out | tuser: kind; tdata: red, green, blue, anomaly_low, anomaly_high
//
// Load is a row sum/count read-modify-write.
// Read pixel runs the 16-step serial divider.
// Finish runs a 25-step mean divide per row, then one frame-store read per
// cell through the single read port.
// Synchronous active-low reset; row statistics clear through per-row valid bits.
// A result waits in the output register; the next beat is taken meanwhile.
`default_nettype none
module zonal_anomaly_colormap (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,  // column[7:0] row[14:8] sample[30:15] sample_valid[31]
    input  wire  [1:0]  i_s_axis_tuser,  // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,  // red[7:0] green[15:8] blue[23:16]
                                         // anomaly_low[40:24] anomaly_high[57:41] zero[63:58]
    output logic [0:0]  o_m_axis_tuser   // kind[0]
);
    zac_pkg::t_cmd cmd;
    zac_pkg::t_sts sts;
    logic        kind;
    logic [7:0]  red, green, blue;
    logic [16:0] alo, ahi;

    zac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_mode  (i_s_axis_tuser),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    zac_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_column       (i_s_axis_tdata[7:0]),
        .i_row          (i_s_axis_tdata[14:8]),
        .i_sample       (i_s_axis_tdata[30:15]),
        .i_sample_valid (i_s_axis_tdata[31]),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_kind         (kind),
        .o_red          (red),
        .o_green        (green),
        .o_blue         (blue),
        .o_anomaly_low  (alo),
        .o_anomaly_high (ahi)
    );

    assign o_m_axis_tdata = {6'd0, ahi, alo, blue, green, red};
    assign o_m_axis_tuser = kind;
endmodule
`default_nettype wire

[rtl/zac_chk.sv]
`default_nettype none
module zac_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire [1:0]  i_s_axis_tuser,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [63:0] o_m_axis_tdata,
    input wire [0:0]  o_m_axis_tuser
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled beat changed");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == zac_pkg::MODE_LOAD
        && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("load produced a result");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[0] ? (o_m_axis_tdata[23:0] == 24'd0)
                                               : (o_m_axis_tdata[63:24] == 40'd0)))
        else $error("unused result fields not zero");
endmodule

bind zonal_anomaly_colormap zac_chk u_zac_chk (.*);
`default_nettype wire
